@@ hdl/assert_macros.svh @@
// Assertion helpers; define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/nnscl_pkg.sv @@
package nnscl_pkg;

  localparam int CFG_BITS   = 7;   // size register width
  localparam int POS_BITS   = 6;   // destination coordinate width
  localparam int ADDR_BITS  = 12;  // source address / index port width
  localparam int PORT_BITS  = 32;  // pixel port width
  localparam int IDX_W      = 2 * CFG_BITS;

  localparam int DEF_MAX_DIM    = 64;
  localparam int DEF_PIXEL_BITS = 32;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [CFG_BITS-1:0] SIZE_RESET = 7'd64;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // zero counts as one, anything above max_dim as max_dim
  function automatic logic [CFG_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] r,
                                                    input int max_dim);
    logic [CFG_BITS-1:0] res;
    res = r;
    if (r == '0) begin
      res = CFG_BITS'(1);
    end else if (int'(r) > max_dim) begin
      res = CFG_BITS'(max_dim);
    end
    return res;
  endfunction

endpackage

@@ hdl/nnscl_div.sv @@
// Shift-subtract divider: step = (size << FRAC_BITS) / dest + 1, one quotient bit a cycle.
module nnscl_div
  import nnscl_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int STEP_W    = CFG_BITS + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CFG_BITS-1:0] size,
  input  logic [CFG_BITS-1:0] dest,
  output logic                busy,
  output logic [STEP_W-1:0]   step
);

  localparam int CNT_W = $clog2(STEP_W + 1);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'((64'd1 << FRAC_BITS) + 64'd1);

  logic [STEP_W-1:0]   dvd;
  logic [STEP_W-1:0]   quo;
  logic [CFG_BITS-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic [CFG_BITS:0]   trial;
  logic                qbit;
  logic [CFG_BITS-1:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[STEP_W-1]};
    qbit     = trial >= {1'b0, dest};
    rem_next = qbit ? CFG_BITS'(trial - {1'b0, dest}) : CFG_BITS'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      step <= STEP_RESET;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEP_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        step <= {quo[STEP_W-2:0], qbit} + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {size, FRAC_BITS'(0)};
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[STEP_W-2:0], 1'b0};
      quo <= {quo[STEP_W-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule

@@ hdl/nearest_neighbor_image_scaler_core.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_stall   | command, src_addr, pixel_value, out_col, out_row
// out      | out_valid / out_stall | scaled_pixel, source_index
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; a read passes one multiply stage, one clamp
// stage and then the single-port image memory before its pixel returns.
// A register write stalls the input while the two shift-subtract dividers rebuild
// the step ratios.
// Reset loads the steps for 64/64; the image memory is not cleared.
// A stalled output holds; the input keeps taking items until the pipeline is full.
`include "assert_macros.svh"
module nearest_neighbor_image_scaler_core
  import nnscl_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [ADDR_BITS-1:0] src_addr,
  input  logic [PORT_BITS-1:0] pixel_value,
  input  logic [POS_BITS-1:0]  out_col,
  input  logic [POS_BITS-1:0]  out_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PORT_BITS-1:0] scaled_pixel,
  output logic [ADDR_BITS-1:0] source_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data
);

  localparam int STEP_W    = CFG_BITS + FRAC_BITS;
  localparam int PROD_W    = POS_BITS + STEP_W;
  localparam int COORD_W   = PROD_W - FRAC_BITS;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(MEM_DEPTH);

  // configuration
  logic [CFG_BITS-1:0] src_width, src_height, dst_width, dst_height;
  logic [CFG_BITS-1:0] eff_sw, eff_sh, eff_dw, eff_dh;
  logic                recalc;
  logic                div_busy_c, div_busy_r, busy;
  logic [STEP_W-1:0]   col_step, row_step;
  logic                cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_RESET;
      src_height <= SIZE_RESET;
      dst_width  <= SIZE_RESET;
      dst_height <= SIZE_RESET;
      recalc     <= 1'b0;
    end else begin
      recalc <= cfg_xfer;
      if (cfg_xfer) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_width  <= cfg_data;
          REG_SRC_HEIGHT: src_height <= cfg_data;
          REG_DST_WIDTH:  dst_width  <= cfg_data;
          REG_DST_HEIGHT: dst_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    eff_sw = eff_size(src_width, MAX_DIM);
    eff_sh = eff_size(src_height, MAX_DIM);
    eff_dw = eff_size(dst_width, MAX_DIM);
    eff_dh = eff_size(dst_height, MAX_DIM);
  end

  nnscl_div #(.FRAC_BITS(FRAC_BITS), .STEP_W(STEP_W)) u_col_div (
    .clk(clk), .rst(rst), .start(recalc), .size(eff_sw), .dest(eff_dw),
    .busy(div_busy_c), .step(col_step)
  );

  nnscl_div #(.FRAC_BITS(FRAC_BITS), .STEP_W(STEP_W)) u_row_div (
    .clk(clk), .rst(rst), .start(recalc), .size(eff_sh), .dest(eff_dh),
    .busy(div_busy_r), .step(row_step)
  );

  assign busy = recalc || div_busy_c || div_busy_r;

  // pipeline control
  logic v1, v2, v3;
  logic cmd1, cmd2;
  logic ready1, ready2, ready3;
  logic mv1, mv2, mv2_rd, acc;

  always_comb begin
    ready3   = !v3 || !out_stall;
    mv2      = v2 && (cmd2 == CMD_WRITE || ready3);
    mv2_rd   = v2 && cmd2 == CMD_READ && ready3;
    ready2   = !v2 || mv2;
    mv1      = v1 && ready2;
    ready1   = !v1 || ready2;
    in_stall = !ready1 || busy;
    acc      = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (acc) begin
        v1 <= 1'b1;
      end else if (mv1) begin
        v1 <= 1'b0;
      end
      if (mv1) begin
        v2 <= 1'b1;
      end else if (mv2) begin
        v2 <= 1'b0;
      end
      if (ready3) begin
        v3 <= mv2_rd;
      end
    end
  end

  // stage 1: coordinate products
  logic [PROD_W-1:0]     prod_c, prod_r;
  logic [ADDR_BITS-1:0]  addr1, addr2;
  logic [PIXEL_BITS-1:0] pix1, pix2;

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd1   <= command;
      prod_c <= PROD_W'(out_col) * PROD_W'(col_step);
      prod_r <= PROD_W'(out_row) * PROD_W'(row_step);
      addr1  <= src_addr;
      pix1   <= PIXEL_BITS'(pixel_value);
    end
  end

  // stage 2: truncate and clamp
  logic [COORD_W-1:0]  hx, hy;
  logic [CFG_BITS-1:0] lim_x, lim_y, x_next, y_next, x2, y2;

  always_comb begin
    hx     = prod_c[PROD_W-1:FRAC_BITS];
    hy     = prod_r[PROD_W-1:FRAC_BITS];
    lim_x  = eff_sw - 1'b1;
    lim_y  = eff_sh - 1'b1;
    x_next = (hx > COORD_W'(lim_x)) ? lim_x : CFG_BITS'(hx);
    y_next = (hy > COORD_W'(lim_y)) ? lim_y : CFG_BITS'(hy);
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      cmd2  <= cmd1;
      x2    <= x_next;
      y2    <= y_next;
      addr2 <= addr1;
      pix2  <= pix1;
    end
  end

  // stage 3: image memory, one access a cycle unless a read is held by out_stall, in item order
  logic [PIXEL_BITS-1:0] image [MEM_DEPTH];
  logic [PIXEL_BITS-1:0] rd_q;
  logic [IDX_W-1:0]      idx;
  logic [ADDR_BITS-1:0]  idx3;
  logic                  wr_en;

  always_comb begin
    idx   = IDX_W'(y2) * IDX_W'(eff_sw) + IDX_W'(x2);
    wr_en = mv2 && cmd2 == CMD_WRITE && (32'(addr2) < 32'(MEM_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      image[AW'(addr2)] <= pix2;
    end
    if (mv2_rd) begin
      rd_q <= image[AW'(idx)];
      idx3 <= ADDR_BITS'(idx);
    end
  end

  assign out_valid    = v3;
  assign scaled_pixel = PORT_BITS'(rd_q);
  assign source_index = idx3;

  `ASSERT_NOW(a_x_in_image, clk, rst, v2 && cmd2 == CMD_READ, x2 < eff_sw && y2 < eff_sh)
  `ASSERT_NEXT(a_cfg_blocks_input, clk, rst, cfg_xfer, in_stall)
  `ASSERT_NEXT(a_read_enters, clk, rst, acc && command == CMD_READ, v1 && cmd1 == CMD_READ)
  `ASSERT_NOW(a_div_in_step, clk, rst, div_busy_c || div_busy_r, div_busy_c && div_busy_r)

endmodule
